// ===== design/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types, widths and codes for the contiguous segment allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 16;
  localparam int OWNER_BITS   = 8;

  // table index; holds up to MAX_SEGMENTS + 1 (tail gap position)
  localparam int IDX_W   = $clog2(MAX_SEGMENTS + 2);
  localparam int TAB_AW  = $clog2(MAX_SEGMENTS);
  localparam int PADDR_W = 3;

  // operation codes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_COMPACT = 2'd2;

  // placement rules
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_GAP   = 2'd1;
  localparam logic [1:0] ST_NO_OWNER = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_MEMORY_SIZE = PADDR_W'(0);

  localparam logic [ADDR_BITS-1:0] MEMORY_SIZE_RST = ADDR_BITS'(65535);

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [OWNER_BITS-1:0] owner_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // one table entry: [seg_base, seg_end) owned by seg_owner
  typedef struct packed {
    addr_t  seg_base;
    addr_t  seg_end;
    owner_t seg_owner;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_cur;
    logic       rd_prev;
    logic       rd_next;
    logic       gap_eval;
    logic       own_miss;
    logic       shift_init;
    logic       wr_up;
    logic       insert;
    logic       wr_down;
    logic       rel_done;
    logic       cmp_wr;
    logic       set_res;
    logic [1:0] res_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       reject;
    logic       strat_bad;
    logic       idx_lt_cnt;
    logic       idx_gt_cnt;
    logic       found;
    logic       first_done;
    logic       idx_gt_pick;
    logic       next_lt_cnt;
    logic       owner_hit;
  } sts_t;

endpackage

// ===== design/csa_req_if.sv =====
// ----------------------------------------------------------------------------
// csa_req_if
// Request channel: operation, owner, size and placement rule.
// ----------------------------------------------------------------------------
interface csa_req_if;
  import csa_pkg::*;

  logic   valid;
  logic   ready;
  logic [1:0] mode;
  owner_t owner_id;
  addr_t  alloc_size;
  logic [1:0] fit_rule;

  modport source (output valid, mode, owner_id, alloc_size, fit_rule, input ready);
  modport sink   (input valid, mode, owner_id, alloc_size, fit_rule, output ready);
endinterface

// ===== design/csa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// csa_rsp_if
// Response channel: status and base address of a new segment.
// ----------------------------------------------------------------------------
interface csa_rsp_if;
  import csa_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] status;
  addr_t      base_address;

  modport source (output valid, status, base_address, input ready);
  modport sink   (input valid, status, base_address, output ready);
endinterface

// ===== design/csa_ram.sv =====
// ----------------------------------------------------------------------------
// csa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/csa_dp.sv =====
// ----------------------------------------------------------------------------
// csa_dp
// Datapath: segment table RAM, scan registers, gap arithmetic and result.
// ----------------------------------------------------------------------------
module csa_dp (
  input  logic              clk,
  input  logic              rst,
  input  csa_pkg::cmd_t     cmd,
  output csa_pkg::sts_t     sts,
  input  logic [1:0]        req_mode,
  input  csa_pkg::owner_t   req_owner,
  input  csa_pkg::addr_t    req_size,
  input  logic [1:0]        req_strat,
  input  logic              cfg_we,
  input  csa_pkg::addr_t    cfg_data,
  output csa_pkg::addr_t    memory_size,
  output logic [1:0]        res_status,
  output csa_pkg::addr_t    res_base
);
  import csa_pkg::*;

  // latched transaction fields
  logic [1:0] mode;
  owner_t     owner;
  addr_t      size;
  logic [1:0] strat;

  // scan state
  idx_t   count;
  idx_t   idx;
  addr_t  prev_end;
  logic   found;
  idx_t   pick;
  addr_t  pick_gap;
  addr_t  pick_lo;

  // table RAM
  logic                  ram_we;
  logic [TAB_AW-1:0]     ram_waddr;
  entry_t                ram_wdata;
  logic [TAB_AW-1:0]     ram_raddr;
  entry_t                rdata;
  idx_t                  rd_idx;

  csa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SEGMENTS)) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // gap in front of slot idx; tail gap ends at memory_size
  addr_t gap_stop;
  addr_t gap;
  logic  gap_take;
  addr_t seg_len;
  addr_t cmp_end;

  always_comb begin
    gap_stop = (idx < count) ? rdata.seg_base : memory_size;
    gap      = (gap_stop > prev_end) ? addr_t'(gap_stop - prev_end) : '0;
    gap_take = (gap >= size) &&
               (!found || (strat == FIT_BEST && gap < pick_gap) ||
                (strat == FIT_WORST && gap > pick_gap));
    seg_len  = addr_t'(rdata.seg_end - rdata.seg_base);
    cmp_end  = addr_t'(prev_end + seg_len);
  end

  // read address select
  always_comb begin
    rd_idx = idx;
    if (cmd.rd_prev) begin
      rd_idx = idx_t'(idx - idx_t'(1));
    end else if (cmd.rd_next) begin
      rd_idx = idx_t'(idx + idx_t'(1));
    end
    ram_raddr = rd_idx[TAB_AW-1:0];
  end

  // write port
  always_comb begin
    ram_we    = cmd.wr_up | cmd.insert | cmd.wr_down | cmd.cmp_wr;
    ram_waddr = idx[TAB_AW-1:0];
    ram_wdata = rdata;
    if (cmd.insert) begin
      ram_waddr           = pick[TAB_AW-1:0];
      ram_wdata.seg_base  = pick_lo;
      ram_wdata.seg_end   = addr_t'(pick_lo + size);
      ram_wdata.seg_owner = owner;
    end else if (cmd.cmp_wr) begin
      ram_wdata.seg_base  = prev_end;
      ram_wdata.seg_end   = cmp_end;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      memory_size <= MEMORY_SIZE_RST;
    end else begin
      if (cfg_we) begin
        memory_size <= cfg_data;
      end
      if (cmd.insert) begin
        count <= idx_t'(count + idx_t'(1));
      end else if (cmd.rel_done) begin
        count <= idx_t'(count - idx_t'(1));
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= req_mode;
      owner    <= req_owner;
      size     <= req_size;
      strat    <= req_strat;
      idx      <= '0;
      prev_end <= '0;
      found    <= 1'b0;
    end
    if (cmd.gap_eval) begin
      if (gap_take) begin
        found    <= 1'b1;
        pick     <= idx;
        pick_gap <= gap;
        pick_lo  <= prev_end;
      end
      prev_end <= rdata.seg_end;
      idx      <= idx_t'(idx + idx_t'(1));
    end
    if (cmd.own_miss || cmd.wr_down) begin
      idx <= idx_t'(idx + idx_t'(1));
    end
    if (cmd.shift_init) begin
      idx <= count;
    end
    if (cmd.wr_up) begin
      idx <= idx_t'(idx - idx_t'(1));
    end
    if (cmd.cmp_wr) begin
      prev_end <= cmp_end;
      idx      <= idx_t'(idx + idx_t'(1));
    end
    if (cmd.insert) begin
      res_status <= ST_OK;
      res_base   <= pick_lo;
    end else if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_base   <= '0;
    end
  end

  // status to controller
  always_comb begin
    sts.mode        = mode;
    sts.reject      = (size == '0) || (count >= idx_t'(MAX_SEGMENTS));
    sts.strat_bad   = (strat != FIT_FIRST) && (strat != FIT_BEST) && (strat != FIT_WORST);
    sts.idx_lt_cnt  = idx < count;
    sts.idx_gt_cnt  = idx > count;
    sts.found       = found;
    sts.first_done  = found && (strat == FIT_FIRST);
    sts.idx_gt_pick = idx > pick;
    sts.next_lt_cnt = idx_t'(idx + idx_t'(1)) < count;
    sts.owner_hit   = rdata.seg_owner == owner;
  end

endmodule

// ===== design/csa_ctrl.sv =====
// ----------------------------------------------------------------------------
// csa_ctrl
// Controller: sequences the scan, shift, insert and compact steps.
// ----------------------------------------------------------------------------
module csa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  csa_pkg::sts_t sts,
  output csa_pkg::cmd_t cmd
);
  import csa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_EV   = 4'd3;
  localparam logic [3:0] S_A_CHK  = 4'd4;
  localparam logic [3:0] S_A_SH   = 4'd5;
  localparam logic [3:0] S_A_SHW  = 4'd6;
  localparam logic [3:0] S_R_RD   = 4'd7;
  localparam logic [3:0] S_R_EV   = 4'd8;
  localparam logic [3:0] S_R_SH   = 4'd9;
  localparam logic [3:0] S_R_SHW  = 4'd10;
  localparam logic [3:0] S_C_RD   = 4'd11;
  localparam logic [3:0] S_C_WR   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority case (sts.mode)
          MODE_ALLOC: begin
            if (sts.reject) begin
              cmd.set_res = 1'b1;
              cmd.res_code = ST_REJECT;
              state_next   = S_DONE;
            end else if (sts.strat_bad) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_NO_GAP;
              state_next   = S_DONE;
            end else begin
              state_next = S_A_RD;
            end
          end
          MODE_RELEASE: state_next = S_R_RD;
          MODE_COMPACT: state_next = S_C_RD;
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end
        endcase
      end
      // gap scan: one read, one evaluate per slot
      S_A_RD: begin
        cmd.rd_cur = sts.idx_lt_cnt;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        cmd.gap_eval = 1'b1;
        state_next   = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.first_done || sts.idx_gt_cnt) begin
          if (sts.found) begin
            cmd.shift_init = 1'b1;
            state_next     = S_A_SH;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NO_GAP;
            state_next   = S_DONE;
          end
        end else begin
          state_next = S_A_RD;
        end
      end
      // open a slot at pick by moving entries up
      S_A_SH: begin
        if (sts.idx_gt_pick) begin
          cmd.rd_prev = 1'b1;
          state_next  = S_A_SHW;
        end else begin
          cmd.insert = 1'b1;
          state_next = S_DONE;
        end
      end
      S_A_SHW: begin
        cmd.wr_up  = 1'b1;
        state_next = S_A_SH;
      end
      // owner search
      S_R_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_cur = 1'b1;
          state_next = S_R_EV;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_OWNER;
          state_next   = S_DONE;
        end
      end
      S_R_EV: begin
        if (sts.owner_hit) begin
          state_next = S_R_SH;
        end else begin
          cmd.own_miss = 1'b1;
          state_next   = S_R_RD;
        end
      end
      // close the slot by moving entries down
      S_R_SH: begin
        if (sts.next_lt_cnt) begin
          cmd.rd_next = 1'b1;
          state_next  = S_R_SHW;
        end else begin
          cmd.rel_done = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_DONE;
        end
      end
      S_R_SHW: begin
        cmd.wr_down = 1'b1;
        state_next  = S_R_SH;
      end
      // compact: rewrite each entry from the running end
      S_C_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_cur = 1'b1;
          state_next = S_C_WR;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_DONE;
        end
      end
      S_C_WR: begin
        cmd.cmp_wr = 1'b1;
        state_next = S_C_RD;
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/contiguous_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_segment_allocator
// Address-ordered segment table with first/best/worst-fit allocate, release
// and compact, configured over an APB-style port.
// ----------------------------------------------------------------------------
// One transaction at a time. The segment table sits in a single RAM with one
// read and one write port and registered read data, so each table entry
// visited is first read and then used. Allocate scans the gaps slot by slot,
// then moves entries up to open a slot; release searches for the owner, then
// moves entries down; compact rewrites each entry in turn. The result then
// waits in its register until taken.
// memory_size may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module contiguous_segment_allocator (
  input  logic                          clk,
  input  logic                          rst,
  csa_req_if.sink                       req,
  csa_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import csa_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  logic  cfg_we;
  addr_t memory_size;

  // register access decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_MEMORY_SIZE);
  assign prdata = (paddr == REG_MEMORY_SIZE) ? 32'(memory_size) : '0;

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_mode    (req.mode),
    .req_owner   (req.owner_id),
    .req_size    (req.alloc_size),
    .req_strat   (req.fit_rule),
    .cfg_we      (cfg_we),
    .cfg_data    (pwdata[ADDR_BITS-1:0]),
    .memory_size (memory_size),
    .res_status  (rsp.status),
    .res_base    (rsp.base_address)
  );

endmodule
